FILE: rtl/vnq2d_pkg.sv
// ----------------------------------------------------------------------------
// vnq2d_pkg
// Shared constants for the 2D value noise pipeline: field widths, fixed-point
// formats and the lattice hash constants.
// ----------------------------------------------------------------------------
package vnq2d_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W      = 32;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_W        = 18;
    localparam int OUT_TDATA_W  = 24;
    localparam int CELL_W       = 8;
    localparam int CORNER_W     = 31;
    localparam int CORNER_FB    = 30;
    localparam int OUT_FB       = 16;
    localparam int NUM_STAGES   = 7;

    localparam logic [10:0] MIX_X    = 11'd1619;
    localparam logic [14:0] MIX_Y    = 15'd31337;
    localparam logic [31:0] MIX_OFS  = 32'd1013904223;
    localparam logic [20:0] HASH_MUL = 21'd1664525;

    localparam logic signed [OUT_W-1:0] OUT_ONE = 18'sd65536;

endpackage

FILE: rtl/value_noise_2d_quintic_top.sv
// ----------------------------------------------------------------------------
// value_noise_2d_quintic_top
// Each input word carries an x/y coordinate pair in signed fixed point with
// FRAC_BITS fraction bits; each output word carries one noise value in [-1,1]
// as signed Q16. The block is a seven-stage pipeline that takes one word per
// clock while the output is not holding it back; the rate is set
// by the per-stage handshake, in which each stage loads whenever it is empty
// or the stage after it moves. Empty stages close up while the output waits,
// so words keep being accepted until the pipeline is full. Stages: fraction
// square and corner mix, fraction cube and corner hash multiply, fade
// multiply and corner differences, x blend products, x blend sums and y
// difference, y blend product, y blend sum and output scaling. There is no
// state between words.
// ----------------------------------------------------------------------------
module value_noise_2d_quintic_top
    import vnq2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_coord[31:0], y_coord[63:32]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // noise_value[17:0], zero pad
);

    localparam int FW = FRAC_BITS;
    localparam int PW = FRAC_BITS + 4;
    localparam int SH = CORNER_FB - OUT_FB;

    // handshake
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = ~r_vld[NUM_STAGES-1] | m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
        n_vld[0] = w_en[0] ? s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES-1];

    // stage 1: fraction square, corner mix
    logic [COORD_W-1:0] w_x, w_y;
    logic [FW-1:0]      w_tx, w_ty;
    logic [2*FW-1:0]    w_sqx, w_sqy;
    logic [CELL_W:0]    w_cx0, w_cx1, w_cy0, w_cy1;
    logic [19:0]        w_lx0, w_lx1;
    logic [22:0]        w_ly0, w_ly1;
    logic [31:0]        w_lin [4];

    always_comb begin
        w_x    = s_axis_tdata[COORD_W-1:0];
        w_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
        w_tx   = w_x[FW-1:0];
        w_ty   = w_y[FW-1:0];
        w_sqx  = w_tx * w_tx;
        w_sqy  = w_ty * w_ty;
        w_cx0  = {1'b0, w_x[FW +: CELL_W]};
        w_cy0  = {1'b0, w_y[FW +: CELL_W]};
        w_cx1  = w_cx0 + (CELL_W+1)'(1);
        w_cy1  = w_cy0 + (CELL_W+1)'(1);
        w_lx0  = 20'(w_cx0) * 20'(MIX_X);
        w_lx1  = 20'(w_cx1) * 20'(MIX_X);
        w_ly0  = 23'(w_cy0) * 23'(MIX_Y);
        w_ly1  = 23'(w_cy1) * 23'(MIX_Y);
        w_lin[0] = MIX_OFS + 32'(w_lx0) + 32'(w_ly0);
        w_lin[1] = MIX_OFS + 32'(w_lx1) + 32'(w_ly0);
        w_lin[2] = MIX_OFS + 32'(w_lx0) + 32'(w_ly1);
        w_lin[3] = MIX_OFS + 32'(w_lx1) + 32'(w_ly1);
    end

    logic [FW-1:0] r1_tx, r1_ty, r1_t2x, r1_t2y;
    logic [31:0]   r1_lin [4];

    // stage 2: fraction cube, fade polynomial, corner hash
    logic [2*FW-1:0]     w_cbx, w_cby;
    logic [PW-1:0]       w_px, w_py;
    logic [31:0]         w_h [4];
    logic [CORNER_W-1:0] w_g [4];

    always_comb begin
        w_cbx = r1_t2x * r1_tx;
        w_cby = r1_t2y * r1_ty;
        w_px  = (PW'(r1_t2x) * PW'(6)) + (PW'(10) << FW) - (PW'(r1_tx) * PW'(15));
        w_py  = (PW'(r1_t2y) * PW'(6)) + (PW'(10) << FW) - (PW'(r1_ty) * PW'(15));
        for (int j = 0; j < 4; j++) begin
            w_h[j] = r1_lin[j] * 32'(HASH_MUL);
            // low 31 bits minus 2^30
            w_g[j] = {~w_h[j][CORNER_W-1], w_h[j][CORNER_W-2:0]};
        end
    end

    logic [FW-1:0]       r2_t3x, r2_t3y;
    logic [PW-1:0]       r2_px, r2_py;
    logic [CORNER_W-1:0] r2_g [4];

    // stage 3: fade, x differences
    logic [2*FW+3:0]     w_fxp, w_fyp;
    logic [CORNER_W:0]   w_d0, w_d1;
    logic [CORNER_W:0]   w_m0, w_m1;

    always_comb begin
        w_fxp = r2_t3x * r2_px;
        w_fyp = r2_t3y * r2_py;
        w_d0  = {r2_g[1][CORNER_W-1], r2_g[1]} - {r2_g[0][CORNER_W-1], r2_g[0]};
        w_d1  = {r2_g[3][CORNER_W-1], r2_g[3]} - {r2_g[2][CORNER_W-1], r2_g[2]};
        w_m0  = w_d0[CORNER_W] ? -w_d0 : w_d0;
        w_m1  = w_d1[CORNER_W] ? -w_d1 : w_d1;
    end

    logic [FW:0]         r3_fu, r3_fv;
    logic [CORNER_W-1:0] r3_a0, r3_a1, r3_m0, r3_m1;
    logic                r3_n0, r3_n1;

    // stage 4: x blend products
    logic [FW+CORNER_W:0] w_pr0, w_pr1;

    always_comb begin
        w_pr0 = r3_m0 * r3_fu;
        w_pr1 = r3_m1 * r3_fu;
    end

    logic [CORNER_W-1:0] r4_a0, r4_a1, r4_p0, r4_p1;
    logic                r4_n0, r4_n1;
    logic [FW:0]         r4_fv;

    // stage 5: x blend sums, y difference
    logic [CORNER_W-1:0] w_ix0, w_ix1;
    logic [CORNER_W:0]   w_dy, w_my;

    always_comb begin
        w_ix0 = r4_n0 ? (r4_a0 - r4_p0) : (r4_a0 + r4_p0);
        w_ix1 = r4_n1 ? (r4_a1 - r4_p1) : (r4_a1 + r4_p1);
        w_dy  = {w_ix1[CORNER_W-1], w_ix1} - {w_ix0[CORNER_W-1], w_ix0};
        w_my  = w_dy[CORNER_W] ? -w_dy : w_dy;
    end

    logic [CORNER_W-1:0] r5_a, r5_m;
    logic                r5_n;
    logic [FW:0]         r5_fv;

    // stage 6: y blend product
    logic [FW+CORNER_W:0] w_pry;

    assign w_pry = r5_m * r5_fv;

    logic [CORNER_W-1:0] r6_a, r6_p;
    logic                r6_n;

    // stage 7: y blend sum, scale to q16 toward zero
    logic [CORNER_W-1:0]    w_r, w_rm;
    logic [CORNER_W-SH-1:0] w_qm;
    logic [OUT_W-1:0]       w_q;

    always_comb begin
        w_r  = r6_n ? (r6_a - r6_p) : (r6_a + r6_p);
        w_rm = w_r[CORNER_W-1] ? -w_r : w_r;
        w_qm = w_rm[CORNER_W-1:SH];
        w_q  = w_r[CORNER_W-1] ? -{1'b0, w_qm} : {1'b0, w_qm};
    end

    logic [OUT_W-1:0] r7_q;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_tx  <= w_tx;
            r1_ty  <= w_ty;
            r1_t2x <= w_sqx[2*FW-1:FW];
            r1_t2y <= w_sqy[2*FW-1:FW];
            for (int j = 0; j < 4; j++) begin
                r1_lin[j] <= w_lin[j];
            end
        end
        if (w_en[1]) begin
            r2_t3x <= w_cbx[2*FW-1:FW];
            r2_t3y <= w_cby[2*FW-1:FW];
            r2_px  <= w_px;
            r2_py  <= w_py;
            for (int j = 0; j < 4; j++) begin
                r2_g[j] <= w_g[j];
            end
        end
        if (w_en[2]) begin
            r3_fu <= w_fxp[2*FW:FW];
            r3_fv <= w_fyp[2*FW:FW];
            r3_a0 <= r2_g[0];
            r3_a1 <= r2_g[2];
            r3_m0 <= w_m0[CORNER_W-1:0];
            r3_m1 <= w_m1[CORNER_W-1:0];
            r3_n0 <= w_d0[CORNER_W];
            r3_n1 <= w_d1[CORNER_W];
        end
        if (w_en[3]) begin
            r4_a0 <= r3_a0;
            r4_a1 <= r3_a1;
            r4_p0 <= w_pr0[FW+CORNER_W-1:FW];
            r4_p1 <= w_pr1[FW+CORNER_W-1:FW];
            r4_n0 <= r3_n0;
            r4_n1 <= r3_n1;
            r4_fv <= r3_fv;
        end
        if (w_en[4]) begin
            r5_a  <= w_ix0;
            r5_m  <= w_my[CORNER_W-1:0];
            r5_n  <= w_dy[CORNER_W];
            r5_fv <= r4_fv;
        end
        if (w_en[5]) begin
            r6_a <= r5_a;
            r6_p <= w_pry[FW+CORNER_W-1:FW];
            r6_n <= r5_n;
        end
        if (w_en[6]) begin
            r7_q <= w_q;
        end
    end

    assign m_axis_tdata = {(OUT_TDATA_W-OUT_W)'(0), r7_q};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits not cleared by reset");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_vld & $past(r_vld & ~w_en)) == $past(r_vld & ~w_en)))
        else $error("stalled stage dropped its word");

    a_fade_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_fu[FW] == 1'b0) && (r3_fv[FW] == 1'b0))
        else $error("fade reached one");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r7_q) <= OUT_ONE) && ($signed(r7_q) >= -OUT_ONE))
        else $error("noise value out of range");

endmodule

FILE: dv/tb_value_noise_2d_quintic_top.sv
// ----------------------------------------------------------------------------
// tb_value_noise_2d_quintic_top
// Streams coordinate pairs into the 2D value noise pipeline and compares every
// output word with a built-in bit-accurate predictor. It runs a directed set
// first: extremes, lattice cell 255 with its unwrapped upper corner, negative
// coordinates and fraction edges. Random traffic follows in phases with no
// idling, a sparse sender, a stalling receiver and light idling on both sides.
// One long receiver hold-off fills the pipeline and backs up the input.
// ----------------------------------------------------------------------------
module tb_value_noise_2d_quintic_top;
    import vnq2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // x_coord[31:0], y_coord[63:32]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // noise_value[17:0], zero pad

    logic [IN_TDATA_W-1:0]  coord_queue[$];
    logic [OUT_W-1:0]       noise_expected[$];
    logic [OUT_W-1:0]       noise_want;
    logic                   in_acc = 1'b0;
    logic                   hold_go = 1'b0;
    logic                   hold_done = 1'b0;
    int                     words_queued = 0;
    int                     words_sent = 0;
    int                     fails = 0;
    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     hold_left = 0;

    value_noise_2d_quintic_top #(.FRAC_BITS(FB)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // quintic fade of an unsigned fraction, every shift truncating
    function automatic longint unsigned fade_q(longint unsigned t);
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned p;
        t2 = (t * t) >> FB;
        t3 = (t2 * t) >> FB;
        p  = 6 * t2 + 10 * (64'd1 << FB) - 15 * t;
        return (t3 * p) >> FB;
    endfunction

    // corner hash mapped to [-1,1) in q30
    function automatic longint signed lattice_value(bit [31:0] cx, bit [31:0] cy);
        bit [31:0]      h;
        longint signed  g;
        h = cx * 32'd1619 + cy * 32'd31337 + 32'd1013904223;
        h = h * 32'd1664525;
        g = h[30:0];
        return g - 64'sd1073741824;
    endfunction

    function automatic longint signed lerp_trunc(longint signed a, longint signed b,
                                                 longint unsigned f);
        longint signed   d;
        longint unsigned m;
        d = b - a;
        m = (d < 0) ? -d : d;
        m = (m * f) >> FB;
        return (d < 0) ? a - $signed(m) : a + $signed(m);
    endfunction

    function automatic logic [OUT_W-1:0] noise_of(logic [31:0] xc, logic [31:0] yc);
        bit [31:0]       xi;
        bit [31:0]       yi;
        longint unsigned u;
        longint unsigned v;
        longint signed   ix0;
        longint signed   ix1;
        longint signed   r;
        longint unsigned m;
        longint signed   q;
        xi  = {24'd0, xc[FB +: CELL_W]};
        yi  = {24'd0, yc[FB +: CELL_W]};
        u   = fade_q(xc & ((64'd1 << FB) - 1));
        v   = fade_q(yc & ((64'd1 << FB) - 1));
        // upper corner index is not wrapped, so 255 + 1 hashes as 256
        ix0 = lerp_trunc(lattice_value(xi, yi), lattice_value(xi + 1, yi), u);
        ix1 = lerp_trunc(lattice_value(xi, yi + 1), lattice_value(xi + 1, yi + 1), u);
        r   = lerp_trunc(ix0, ix1, v);
        m   = (r < 0) ? -r : r;
        m   = m >> (CORNER_FB - OUT_FB);
        q   = (r < 0) ? -$signed(m) : $signed(m);
        return q[OUT_W-1:0];
    endfunction

    task automatic queue_coord(logic [31:0] xc, logic [31:0] yc);
        coord_queue.push_back({yc, xc});
        words_queued++;
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(9))
            4: c[FB +: CELL_W] = 8'hFF;
            5: c[FB-1:0] = ($urandom_range(1) != 0) ? '1 : '0;
            6: c = $urandom_range(1) ? -$urandom_range(1 << 18) : $urandom_range(1 << 18);
            7: begin
                case ($urandom_range(3))
                    0: c = 32'h8000_0000;
                    1: c = 32'h7FFF_FFFF;
                    2: c = 32'h0000_0000;
                    default: c = 32'hFFFF_FFFF;
                endcase
            end
            8: c[FB-1:0] = $urandom_range(1) ? $urandom_range(15) : '1 - $urandom_range(15);
            default: ;
        endcase
        return c;
    endfunction

    task automatic run_random(int n_words, int sender_idle, int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (n_words) queue_coord(pick_coord(), pick_coord());
    endtask

    task automatic drain();
        while (words_sent != words_queued || noise_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_acc) begin
            if (coord_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_axis_tdata  <= coord_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver long hold-off
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // predict on every accepted coordinate word, check every output word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_acc <= 1'b0;
        end else begin
            in_acc <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                noise_expected.push_back(noise_of(s_axis_tdata[31:0], s_axis_tdata[63:32]));
                words_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (noise_expected.size() == 0) begin
                    $error("noise_value: no word expected, got %0d",
                           $signed(m_axis_tdata[OUT_W-1:0]));
                    fails++;
                end else begin
                    noise_want = noise_expected.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== noise_want) begin
                        $error("noise_value: expected %0d, got %0d",
                               $signed(noise_want), $signed(m_axis_tdata[OUT_W-1:0]));
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words, no idling
        idle_pct  = 0;
        stall_pct = 0;
        queue_coord(32'h0000_0000, 32'h0000_0000);
        queue_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_coord(32'h8000_0000, 32'h8000_0000);
        queue_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_coord(32'h00FF_0000, 32'h00FF_8000);
        queue_coord(32'h00FF_FFFF, 32'h0000_0000);
        queue_coord(32'h0000_0000, 32'h00FF_FFFF);
        queue_coord(32'h0000_FFFF, 32'h0000_FFFF);
        queue_coord(32'h0000_8000, 32'h0000_4000);
        queue_coord(32'hFFFF_8000, 32'h0001_0000);
        queue_coord(32'h7FFF_0000, 32'h8000_FFFF);
        queue_coord(32'h8000_FFFF, 32'h7FFF_0000);
        queue_coord(32'h1234_5678, 32'h9ABC_DEF0);
        queue_coord(32'hAAAA_AAAA, 32'h5555_5555);
        queue_coord(32'h5555_5555, 32'hAAAA_AAAA);
        queue_coord(32'h0000_0001, 32'h0001_0001);
        queue_coord(32'hFFFF_0000, 32'h00FF_0001);
        queue_coord(32'h0100_0000, 32'hFF00_0000);
        queue_coord(32'hFFFE_FFFF, 32'hFF80_0001);
        queue_coord(32'h00FE_C000, 32'h00FF_3FFF);
        drain();

        run_random(350, 0, 0);
        drain();
        run_random(350, 57, 0);
        drain();
        run_random(350, 0, 57);
        drain();
        run_random(300, 6, 6);
        drain();

        // long receiver hold-off while the sender keeps offering
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge i_clk);
        hold_go = 1'b1;
        run_random(60, 0, 0);
        drain();

        repeat (20) @(negedge i_clk);
        if (noise_expected.size() != 0) begin
            $error("noise_value: %0d words never arrived", noise_expected.size());
            fails++;
        end
        if (fails == 0) begin
            $display("tb_value_noise_2d_quintic_top: clean");
        end else begin
            $display("tb_value_noise_2d_quintic_top: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_value_noise_2d_quintic_top: errors");
        $finish;
    end

endmodule
